[rtl/fesg_pkg.sv]
// ----------------------------------------------------------------------------
// Filled ellipse span generator package
// Shared widths, register indexes and the walk phase type.
// ----------------------------------------------------------------------------
package fesg_pkg;

   localparam int DEC_BITS       = 48;
   localparam int EDGE_BITS      = 10;
   localparam int ROW_BITS       = 13;
   localparam int CENTER_BITS    = 12;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_RADIUS = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_RADIUS = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y = 4'd3;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_REGION1 = 2'd1,
      PHASE_REGION2 = 2'd2,
      PHASE_CLOSE   = 2'd3
   } phase_type;

endpackage

[rtl/filled_ellipse_span_generator.sv]
// ----------------------------------------------------------------------------
// Filled ellipse span generator
// A request passes stages s1 to s4 and then the one-step walk update into
// the output register; one request is taken every cycle unless rsp_stall
// holds the pipeline back.
// The squares and the start decision are prepared in three earlier stages.
// Synchronous reset clears all valid flags, the walk state and the phase.
// ----------------------------------------------------------------------------
module filled_ellipse_span_generator
   import fesg_pkg::*;
#(
   parameter int RADIUS_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [EDGE_BITS-1:0]                rsp_edge_x,
   output logic [EDGE_BITS-1:0]                rsp_edge_y,
   output logic signed [ROW_BITS-1:0]          rsp_upper_row,
   output logic signed [ROW_BITS-1:0]          rsp_lower_row,
   output logic signed [ROW_BITS-1:0]          rsp_span_left,
   output logic signed [ROW_BITS-1:0]          rsp_span_right,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]           csr_index,
   input  logic [((RADIUS_BITS > CENTER_BITS) ? RADIUS_BITS : CENTER_BITS)-1:0] csr_wdata
);

   localparam int SQ_BITS   = 2 * RADIUS_BITS;
   localparam int PROD_BITS = 3 * RADIUS_BITS;

   // Configuration registers
   logic [RADIUS_BITS-1:0]        x_radius_ff;
   logic [RADIUS_BITS-1:0]        y_radius_ff;
   logic signed [CENTER_BITS-1:0] center_x_ff;
   logic signed [CENTER_BITS-1:0] center_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_radius_ff <= RADIUS_BITS'(90);
         y_radius_ff <= RADIUS_BITS'(120);
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_RADIUS: begin
               x_radius_ff <= csr_wdata[RADIUS_BITS-1:0];
            end
            CSR_Y_RADIUS: begin
               y_radius_ff <= csr_wdata[RADIUS_BITS-1:0];
            end
            CSR_CENTER_X: begin
               center_x_ff <= csr_wdata[CENTER_BITS-1:0];
            end
            CSR_CENTER_Y: begin
               center_y_ff <= csr_wdata[CENTER_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline stages
   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                   s1_restart_ff, s2_restart_ff, s3_restart_ff, s4_restart_ff;
   logic [SQ_BITS-1:0]     s2_rx_sq_ff, s3_rx_sq_ff, s4_rx_sq_ff;
   logic [SQ_BITS-1:0]     s2_ry_sq_ff, s3_ry_sq_ff, s4_ry_sq_ff;
   logic [RADIUS_BITS-1:0] s2_ry_ff, s3_ry_ff, s4_ry_ff;
   logic [PROD_BITS-1:0]   s3_prod_ff, s4_prod_ff;
   logic [DEC_BITS-1:0]    s4_dec_ff;

   logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready, s4_fire;
   logic rsp_valid_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s4_fire   = s4_valid_ff && out_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_restart_ff <= req_restart;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_restart_ff <= s1_restart_ff;
         s2_rx_sq_ff   <= SQ_BITS'(x_radius_ff) * SQ_BITS'(x_radius_ff);
         s2_ry_sq_ff   <= SQ_BITS'(y_radius_ff) * SQ_BITS'(y_radius_ff);
         s2_ry_ff      <= y_radius_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_restart_ff <= s2_restart_ff;
         s3_rx_sq_ff   <= s2_rx_sq_ff;
         s3_ry_sq_ff   <= s2_ry_sq_ff;
         s3_ry_ff      <= s2_ry_ff;
         s3_prod_ff    <= PROD_BITS'(s2_rx_sq_ff) * PROD_BITS'(s2_ry_ff);
      end
      if (s4_ready && s3_valid_ff) begin
         s4_restart_ff <= s3_restart_ff;
         s4_rx_sq_ff   <= s3_rx_sq_ff;
         s4_ry_sq_ff   <= s3_ry_sq_ff;
         s4_ry_ff      <= s3_ry_ff;
         s4_prod_ff    <= s3_prod_ff;
         s4_dec_ff     <= DEC_BITS'(s3_ry_sq_ff) - DEC_BITS'(s3_prod_ff)
                          + DEC_BITS'(s3_rx_sq_ff >> 2);
      end
   end

   // Walk state
   logic [RADIUS_BITS-1:0] walk_x_ff, walk_y_ff;
   logic [PROD_BITS-1:0]   prod_x_ff, prod_y_ff;
   logic [DEC_BITS-1:0]    decision_ff;
   logic [SQ_BITS-1:0]     rx_squared_ff, ry_squared_ff;
   phase_type              phase_ff;

   logic [RADIUS_BITS-1:0] walk_x_in, walk_y_in, x_src, y_src;
   logic [PROD_BITS-1:0]   prod_x_in, prod_y_in, px_src, py_src, px_next, py_next;
   logic [DEC_BITS-1:0]    decision_in, d_src;
   logic [SQ_BITS-1:0]     rx_sq_src, ry_sq_src;
   phase_type              phase_in, ph_src, ph_step;

   always_comb begin
      x_src     = s4_restart_ff ? '0 : walk_x_ff;
      y_src     = s4_restart_ff ? s4_ry_ff : walk_y_ff;
      px_src    = s4_restart_ff ? '0 : prod_x_ff;
      py_src    = s4_restart_ff ? s4_prod_ff : prod_y_ff;
      d_src     = s4_restart_ff ? s4_dec_ff : decision_ff;
      rx_sq_src = s4_restart_ff ? s4_rx_sq_ff : rx_squared_ff;
      ry_sq_src = s4_restart_ff ? s4_ry_sq_ff : ry_squared_ff;
      ph_src    = s4_restart_ff ? PHASE_REGION1 : phase_ff;

      px_next = px_src + PROD_BITS'(ry_sq_src);
      py_next = py_src - PROD_BITS'(rx_sq_src);

      ph_step = ph_src;
      if (ph_step == PHASE_REGION1 && !(px_src < py_src)) begin
         ph_step = PHASE_REGION2;
      end
      if (ph_step == PHASE_REGION2 && y_src == '0) begin
         ph_step = PHASE_CLOSE;
      end

      walk_x_in   = x_src;
      walk_y_in   = y_src;
      prod_x_in   = px_src;
      prod_y_in   = py_src;
      decision_in = d_src;
      phase_in    = ph_step;

      unique case (ph_step)
         PHASE_REGION1: begin
            walk_x_in = x_src + RADIUS_BITS'(1);
            prod_x_in = px_next;
            if (d_src[DEC_BITS-1]) begin
               decision_in = d_src + (DEC_BITS'(px_next) << 1) + DEC_BITS'(ry_sq_src);
            end else begin
               walk_y_in   = y_src - RADIUS_BITS'(1);
               prod_y_in   = py_next;
               decision_in = d_src + (DEC_BITS'(px_next) << 1) + DEC_BITS'(ry_sq_src)
                             - (DEC_BITS'(py_next) << 1);
            end
         end
         PHASE_REGION2: begin
            walk_y_in = y_src - RADIUS_BITS'(1);
            prod_y_in = py_next;
            if (d_src[DEC_BITS-1]) begin
               decision_in = d_src + (DEC_BITS'(py_next) << 1) + DEC_BITS'(rx_sq_src);
            end else begin
               walk_x_in   = x_src + RADIUS_BITS'(1);
               prod_x_in   = px_next;
               decision_in = d_src + (DEC_BITS'(py_next) << 1) + DEC_BITS'(rx_sq_src)
                             - (DEC_BITS'(px_next) << 1);
            end
         end
         PHASE_CLOSE: begin
            phase_in = PHASE_IDLE;
         end
         PHASE_IDLE: begin
            phase_in = PHASE_IDLE;
         end
      endcase
   end

   // Emitted point and spans
   logic                       emit_valid, emit_last;
   logic [RADIUS_BITS-1:0]     emit_x, emit_y;
   logic signed [ROW_BITS-1:0] cx_wide, cy_wide, ex_wide, ey_wide;

   always_comb begin
      emit_valid = (ph_step != PHASE_IDLE);
      emit_last  = (ph_step == PHASE_CLOSE);
      emit_x     = emit_last ? x_radius_ff : x_src;
      emit_y     = emit_last ? '0 : y_src;
      cx_wide    = ROW_BITS'(center_x_ff);
      cy_wide    = ROW_BITS'(center_y_ff);
      ex_wide    = ROW_BITS'(emit_x);
      ey_wide    = ROW_BITS'(emit_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         walk_x_ff     <= '0;
         walk_y_ff     <= '0;
         prod_x_ff     <= '0;
         prod_y_ff     <= '0;
         decision_ff   <= '0;
         rx_squared_ff <= '0;
         ry_squared_ff <= '0;
      end else if (s4_fire) begin
         phase_ff      <= phase_in;
         walk_x_ff     <= walk_x_in;
         walk_y_ff     <= walk_y_in;
         prod_x_ff     <= prod_x_in;
         prod_y_ff     <= prod_y_in;
         decision_ff   <= decision_in;
         rx_squared_ff <= rx_sq_src;
         ry_squared_ff <= ry_sq_src;
      end
   end

   logic [EDGE_BITS-1:0]       edge_x_ff, edge_y_ff;
   logic signed [ROW_BITS-1:0] upper_row_ff, lower_row_ff, span_left_ff, span_right_ff;
   logic                       last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s4_fire && emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_fire && emit_valid) begin
         edge_x_ff     <= EDGE_BITS'(emit_x);
         edge_y_ff     <= EDGE_BITS'(emit_y);
         upper_row_ff  <= cy_wide + ey_wide;
         lower_row_ff  <= cy_wide - ey_wide;
         span_left_ff  <= cx_wide - ex_wide + ROW_BITS'(1);
         span_right_ff <= cx_wide + ex_wide - ROW_BITS'(1);
         last_ff       <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_x     = edge_x_ff;
   assign rsp_edge_y     = edge_y_ff;
   assign rsp_upper_row  = upper_row_ff;
   assign rsp_lower_row  = lower_row_ff;
   assign rsp_span_left  = span_left_ff;
   assign rsp_span_right = span_right_ff;
   assign rsp_last       = last_ff;

   // Assertions
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> edge_y_ff == '0)
      else $error("closing request carries a non-zero row offset");

   assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !out_ready |=> s4_valid_ff && $stable(s4_restart_ff))
      else $error("walk stage request lost while the output was stalled");

   assert property (@(posedge clock) disable iff (reset)
      s4_fire && emit_last |=> phase_ff == PHASE_IDLE)
      else $error("walk did not return to idle after the closing span");

   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(!rsp_stall))
      else $error("result dropped without being taken");

endmodule
